// ----- rtl/lcd_window_command_encoder_assert.svh -----
// Assertion macros shared by the window command encoder queue and back-end modules
`ifndef LCD_WINDOW_COMMAND_ENCODER_ASSERT_SVH
`define LCD_WINDOW_COMMAND_ENCODER_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define LCDW_ASSERT_NOW(label, cond_a, cond_b) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond_a) |-> (cond_b)) \
		else $error("lcdw check failed");

// Next-cycle implication, checked out of reset
`define LCDW_ASSERT_NEXT(label, cond_a, cond_b) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond_a) |=> (cond_b)) \
		else $error("lcdw check failed");

`endif

// ----- rtl/lcdw_pkg.sv -----
// Types and constants of the window command encoder
`timescale 1ns / 1ps

package lcdw_pkg;

	// Request opcodes
	localparam logic [1:0] OP_WINDOW = 2'd0;
	localparam logic [1:0] OP_PIXEL  = 2'd1;
	localparam logic [1:0] OP_VOLUME = 2'd2;
	localparam logic [1:0] OP_NONE   = 2'd3;

	// Register indexes
	localparam logic [1:0] CFG_SCREEN_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_SCREEN_HEIGHT = 2'd1;
	localparam logic [1:0] CFG_COLUMN_OFFSET = 2'd2;
	localparam logic [1:0] CFG_ROW_OFFSET    = 2'd3;

	// Register reset values
	localparam logic [7:0] SCREEN_DEFAULT     = 8'd130;
	localparam logic [7:0] COLUMN_OFFSET_RST  = 8'd0;
	localparam logic [7:0] ROW_OFFSET_RST     = 8'd2;

	// Controller command bytes
	localparam logic [7:0] CMD_PAGE_SET  = 8'h75;
	localparam logic [7:0] CMD_COL_SET   = 8'h15;
	localparam logic [7:0] CMD_MEM_WRITE = 8'h5c;
	localparam logic [7:0] CMD_VOLUME    = 8'h81;

	// Job kinds passed from front to back
	localparam logic [1:0] KIND_WINDOW = 2'd0;
	localparam logic [1:0] KIND_OFF    = 2'd1;
	localparam logic [1:0] KIND_PIXEL  = 2'd2;
	localparam logic [1:0] KIND_VOLUME = 2'd3;

	// Frame step codes of a window job
	localparam logic [2:0] STEP_PAGE_CMD  = 3'd0;
	localparam logic [2:0] STEP_ROW_FIRST = 3'd1;
	localparam logic [2:0] STEP_ROW_LAST  = 3'd2;
	localparam logic [2:0] STEP_COL_CMD   = 3'd3;
	localparam logic [2:0] STEP_COL_FIRST = 3'd4;
	localparam logic [2:0] STEP_COL_LAST  = 3'd5;
	localparam logic [2:0] STEP_MEM_WRITE = 3'd6;

	// Frame step codes of a volume job
	localparam logic [2:0] STEP_VOL_CMD   = 3'd0;
	localparam logic [2:0] STEP_VOL_FIRST = 3'd1;

	// Job queue geometry
	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	// One job in the queue
	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  row_first;
		logic [7:0]  row_last;
		logic [7:0]  col_first;
		logic [7:0]  col_last;
		logic [15:0] count;
		logic [7:0]  value_a;
		logic [7:0]  value_b;
	} job_t;

	// One result frame
	typedef struct packed {
		logic        word_valid;
		logic        is_data;
		logic [7:0]  frame_byte;
		logic        off_screen;
		logic [15:0] pixel_count;
		logic        last;
	} frame_t;

endpackage

// ----- rtl/lcdw_front.sv -----
// Front end: registers, request accept, window clipping and job build
`timescale 1ns / 1ps

module lcdw_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [7:0]        cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        opcode,
	input  logic [7:0]        pos_x,
	input  logic [7:0]        pos_y,
	input  logic [7:0]        size_x,
	input  logic [7:0]        size_y,
	input  logic [7:0]        value_a,
	input  logic [7:0]        value_b,
	input  logic              q_full,
	output logic              push,
	output lcdw_pkg::job_t    push_job
);
	import lcdw_pkg::*;

	logic [7:0] screen_width_q;
	logic [7:0] screen_height_q;
	logic [7:0] column_offset_q;
	logic [7:0] row_offset_q;

	logic       accept;
	logic       off;
	logic [8:0] end_x;
	logic [8:0] end_y;
	logic [7:0] dx_clip;
	logic [7:0] dy_clip;
	logic [1:0] kind;

	logic       valid_s1;
	logic [1:0] kind_s1;
	logic [7:0] col_first_s1;
	logic [7:0] row_first_s1;
	logic [7:0] dx_s1;
	logic [7:0] dy_s1;
	logic [7:0] value_a_s1;
	logic [7:0] value_b_s1;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q  <= SCREEN_DEFAULT;
			screen_height_q <= SCREEN_DEFAULT;
			column_offset_q <= COLUMN_OFFSET_RST;
			row_offset_q    <= ROW_OFFSET_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SCREEN_WIDTH:  screen_width_q  <= cfg_data;
				CFG_SCREEN_HEIGHT: screen_height_q <= cfg_data;
				CFG_COLUMN_OFFSET: column_offset_q <= cfg_data;
				CFG_ROW_OFFSET:    row_offset_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Stall only when the stage is full and the queue cannot take it
	assign push     = valid_s1 && !q_full;
	assign in_ready = !valid_s1 || !q_full;
	assign accept   = in_valid && in_ready;

	// Classify request and clip window to the screen edge
	always_comb begin
		off     = (pos_x >= screen_width_q) || (pos_y >= screen_height_q);
		end_x   = {1'b0, pos_x} + {1'b0, size_x};
		end_y   = {1'b0, pos_y} + {1'b0, size_y};
		dx_clip = (end_x > {1'b0, screen_width_q}) ? (screen_width_q - pos_x) : size_x;
		dy_clip = (end_y > {1'b0, screen_height_q}) ? (screen_height_q - pos_y) : size_y;
		unique case (opcode)
			OP_WINDOW: kind = off ? KIND_OFF : KIND_WINDOW;
			OP_PIXEL:  kind = KIND_PIXEL;
			OP_VOLUME: kind = KIND_VOLUME;
			default:   kind = KIND_PIXEL;
		endcase
	end

	// Stage valid: drop unused opcodes, clear on transfer into the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= (opcode != OP_NONE);
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	// Hold classified request
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1      <= kind;
			col_first_s1 <= column_offset_q + pos_x;
			row_first_s1 <= row_offset_q + pos_y;
			dx_s1        <= dx_clip;
			dy_s1        <= dy_clip;
			value_a_s1   <= value_a;
			value_b_s1   <= value_b;
		end
	end

	// Build the job: last coordinates wrap in 8 bits, count is the clipped area
	always_comb begin
		push_job.kind      = kind_s1;
		push_job.row_first = row_first_s1;
		push_job.row_last  = row_first_s1 + dy_s1 + 8'hff;
		push_job.col_first = col_first_s1;
		push_job.col_last  = col_first_s1 + dx_s1 + 8'hff;
		push_job.count     = {8'd0, dx_s1} * {8'd0, dy_s1};
		push_job.value_a   = value_a_s1;
		push_job.value_b   = value_b_s1;
	end

endmodule

// ----- rtl/lcdw_queue.sv -----
// Short job queue between front and back
`timescale 1ns / 1ps
`include "lcd_window_command_encoder_assert.svh"

module lcdw_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  lcdw_pkg::job_t    push_job,
	input  logic              pop,
	output logic              full,
	output logic              empty,
	output lcdw_pkg::job_t    head
);
	import lcdw_pkg::*;

	job_t           mem_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   cnt_q;

	assign full  = (cnt_q == (QAW+1)'(QDEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_ptr_q];

	// Store pushed job
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`LCDW_ASSERT_NOW(a_no_push_full, push, !full)
	`LCDW_ASSERT_NOW(a_no_pop_empty, pop, !empty)
	`LCDW_ASSERT_NEXT(a_cnt_hold, push && pop, $stable(cnt_q))

endmodule

// ----- rtl/lcdw_back.sv -----
// Back end: frame sequencer and output register
`timescale 1ns / 1ps
`include "lcd_window_command_encoder_assert.svh"

module lcdw_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  lcdw_pkg::job_t    head,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output lcdw_pkg::frame_t  out_frame
);
	import lcdw_pkg::*;

	logic [2:0] step_q;
	logic       out_valid_q;
	frame_t     out_q;
	frame_t     frame;
	logic       load;
	logic       take;

	assign load      = !out_valid_q || out_ready;
	assign take      = load && !q_empty;
	assign pop       = take && frame.last;
	assign out_valid = out_valid_q;
	assign out_frame = out_q;

	// Select the frame for the current step of the head job
	always_comb begin
		frame = '0;
		frame.word_valid = 1'b1;
		unique case (head.kind)
			KIND_WINDOW: begin
				unique case (step_q)
					STEP_PAGE_CMD:  frame.frame_byte = CMD_PAGE_SET;
					STEP_ROW_FIRST: begin
						frame.is_data    = 1'b1;
						frame.frame_byte = head.row_first;
					end
					STEP_ROW_LAST: begin
						frame.is_data    = 1'b1;
						frame.frame_byte = head.row_last;
					end
					STEP_COL_CMD:   frame.frame_byte = CMD_COL_SET;
					STEP_COL_FIRST: begin
						frame.is_data    = 1'b1;
						frame.frame_byte = head.col_first;
					end
					STEP_COL_LAST: begin
						frame.is_data    = 1'b1;
						frame.frame_byte = head.col_last;
					end
					default: begin
						frame.frame_byte  = CMD_MEM_WRITE;
						frame.pixel_count = head.count;
						frame.last        = 1'b1;
					end
				endcase
			end
			KIND_OFF: begin
				frame.word_valid = 1'b0;
				frame.off_screen = 1'b1;
				frame.last       = 1'b1;
			end
			KIND_PIXEL: begin
				frame.is_data    = 1'b1;
				frame.frame_byte = head.value_a;
				frame.last       = 1'b1;
			end
			default: begin
				unique case (step_q)
					STEP_VOL_CMD:   frame.frame_byte = CMD_VOLUME;
					STEP_VOL_FIRST: begin
						frame.is_data    = 1'b1;
						frame.frame_byte = head.value_a;
					end
					default: begin
						frame.is_data    = 1'b1;
						frame.frame_byte = head.value_b;
						frame.last       = 1'b1;
					end
				endcase
			end
		endcase
	end

	// Advance step, restart on the last frame of a job
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= !q_empty;
			end
			if (take) begin
				step_q <= frame.last ? 3'd0 : step_q + 1'b1;
			end
		end
	end

	// Load output register
	always_ff @(posedge clk) begin
		if (take) begin
			out_q <= frame;
		end
	end

	`LCDW_ASSERT_NOW(a_step_range, 1'b1, step_q <= STEP_MEM_WRITE)
	`LCDW_ASSERT_NOW(a_off_status, out_valid_q && out_q.off_screen,
		!out_q.word_valid && out_q.last)
	`LCDW_ASSERT_NEXT(a_pop_restart, pop, step_q == 3'd0)

endmodule

// ----- rtl/lcd_window_command_encoder.sv -----
// Top level of the LCD window command encoder
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------------
//  config   | cfg_we               | cfg_index, cfg_data
//  request  | in_valid / in_ready  | opcode, pos_x, pos_y, size_x, size_y, value_a/b
//  frame    | out_valid / out_ready| word_valid, is_data, frame_byte, off_screen,
//           |                      | pixel_count, last
//
// Requests pass the clip stage register and a 4-entry job queue; the back end emits
// one frame per cycle into the output register unless out_ready stalls it. A window
// emits page command, row first/last, column command, column first/last and memory
// write; volume: command, value_a, value_b; pixel or off-screen window: one frame.
// Reset loads screen 130x130, column offset 0, row offset 2 and empties the queue.
// A stalled output holds its frame; the front keeps accepting until the queue fills.
`timescale 1ns / 1ps

module lcd_window_command_encoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  opcode,
	input  logic [7:0]  pos_x,
	input  logic [7:0]  pos_y,
	input  logic [7:0]  size_x,
	input  logic [7:0]  size_y,
	input  logic [7:0]  value_a,
	input  logic [7:0]  value_b,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        word_valid,
	output logic        is_data,
	output logic [7:0]  frame_byte,
	output logic        off_screen,
	output logic [15:0] pixel_count,
	output logic        last
);
	import lcdw_pkg::*;

	logic   push;
	job_t   push_job;
	logic   pop;
	logic   q_full;
	logic   q_empty;
	job_t   head;
	frame_t out_frame;

	lcdw_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.opcode    (opcode),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.size_x    (size_x),
		.size_y    (size_y),
		.value_a   (value_a),
		.value_b   (value_b),
		.q_full    (q_full),
		.push      (push),
		.push_job  (push_job)
	);

	lcdw_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.full     (q_full),
		.empty    (q_empty),
		.head     (head)
	);

	lcdw_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_frame (out_frame)
	);

	// Unpack frame onto output ports
	assign word_valid  = out_frame.word_valid;
	assign is_data     = out_frame.is_data;
	assign frame_byte  = out_frame.frame_byte;
	assign off_screen  = out_frame.off_screen;
	assign pixel_count = out_frame.pixel_count;
	assign last        = out_frame.last;

endmodule
